// ----- sv/dcmf_pkg.sv -----
// shared constants and types of the dark channel minimum filter
package dcmf_pkg;

	localparam int MaxWidthDef  = 2048;
	localparam int MaxWindowDef = 15;
	localparam int HeightCap    = 4096;
	localparam int HgtW         = 13;
	localparam int CfgW         = 13;
	localparam int CfgIdxW      = 2;

	localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] RegWindowSize  = 2'd2;

	localparam logic [7:0] White = 8'd255;

	typedef struct packed {
		logic accept;
		logic step;
		logic load;
	} dcmf_cmd_t;

	typedef struct packed {
		logic emit;
		logic scan_done;
		logic out_free;
	} dcmf_status_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_WAIT  = 4'b1000
	} dcmf_state_t;

endpackage

// ----- sv/dcmf_ram.sv -----
// generic single write port ram with registered read
module dcmf_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- sv/dcmf_ctrl.sv -----
// controller state machine: accept, window scan, drain, result hand-off
module dcmf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  dcmf_pkg::dcmf_status_t status,
	output dcmf_pkg::dcmf_cmd_t    cmd
);
	import dcmf_pkg::*;

	dcmf_state_t state_q, state_d;

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.accept = s_tready && s_tvalid;
		cmd.step   = (state_q == ST_SCAN);
		cmd.load   = (state_q == ST_WAIT) && status.out_free;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.emit) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_WAIT;
			ST_WAIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- sv/dcmf_dp.sv -----
// datapath: config registers, frame counters, line store, window scan, output register
module dcmf_dp #(
	parameter int MaxWidth  = dcmf_pkg::MaxWidthDef,
	parameter int MaxWindow = dcmf_pkg::MaxWindowDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dcmf_pkg::CfgIdxW-1:0]  cfg_addr,
	input  logic [dcmf_pkg::CfgW-1:0]     cfg_data,
	input  logic                          opcode,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    green,
	input  logic [7:0]                    red,
	input  dcmf_pkg::dcmf_cmd_t           cmd,
	output dcmf_pkg::dcmf_status_t        status,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [7:0]                    dark_value,
	output logic                          last_of_frame
);
	import dcmf_pkg::*;

	localparam int Depth = MaxWindow * (MaxWidth + 1);
	localparam int AW    = $clog2(Depth);
	localparam int CW    = $clog2(MaxWidth + 1);
	localparam int SW    = $clog2(MaxWindow + 1);
	localparam int ICW   = $clog2(MaxWidth * HeightCap + MaxWindow * (MaxWidth + 1)) + 1;
	localparam int PW    = HgtW + 2;
	localparam int QW    = CW + 2;

	logic [11:0] wcfg_q;
	logic [12:0] hcfg_q;
	logic [3:0]  scfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcfg_q <= 12'd640;
			hcfg_q <= 13'd480;
			scfg_q <= 4'd15;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegImageWidth:  wcfg_q <= cfg_data[11:0];
				RegImageHeight: hcfg_q <= cfg_data[12:0];
				RegWindowSize:  scfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [CW-1:0]   w;
	logic [HgtW-1:0] h;
	logic [SW-1:0]   s, r, half;
	logic [ICW-1:0]  total, d, limit;
	logic [AW-1:0]   base_delta;

	always_comb begin
		if (wcfg_q == '0) w = CW'(1);
		else if (32'(wcfg_q) > MaxWidth) w = CW'(MaxWidth);
		else w = CW'(wcfg_q);
		if (hcfg_q == '0) h = HgtW'(1);
		else if (32'(hcfg_q) > HeightCap) h = HgtW'(HeightCap);
		else h = HgtW'(hcfg_q);
		if (scfg_q == '0) s = SW'(1);
		else if (32'(scfg_q) > MaxWindow) s = SW'(MaxWindow);
		else s = SW'(scfg_q);
		r          = (s - SW'(1)) >> 1;
		half       = s >> 1;
		total      = ICW'(w) * ICW'(h);
		d          = ICW'(r) * ICW'(w) + ICW'(r);
		limit      = total + d;
		base_delta = AW'(d) + AW'(half) * AW'(w) + AW'(half);
	end

	// frame counters
	logic [ICW-1:0]  item_q, n;
	logic [AW-1:0]   wa_q, wa;
	logic [HgtW-1:0] orow_q, orow;
	logic [CW-1:0]   ocol_q, ocol;
	logic            restart, ign, last_m;
	logic [7:0]      val;

	always_comb begin
		restart = (item_q >= limit);
		n       = restart ? '0 : item_q;
		wa      = restart ? '0 : wa_q;
		orow    = restart ? '0 : orow_q;
		ocol    = restart ? '0 : ocol_q;
		ign     = opcode && (n == '0);
		last_m  = (orow == h - HgtW'(1)) && (ocol == w - CW'(1));
		val = blue;
		if (green < val) val = green;
		if (red < val) val = red;
		if (opcode) val = White;
	end

	// scan registers
	logic [AW-1:0]          base_q, delta_q, rowdelta_q, raddr;
	logic signed [PW-1:0]   p_q;
	logic signed [QW-1:0]   q_q, q0_q;
	logic [SW-1:0]          pi_q, qi_q;
	logic                   last_q, rd_en, rvalid_s1;
	logic [7:0]             min_q, rdata;

	always_comb begin
		rd_en = !p_q[PW-1] && (p_q < $signed({2'b00, h}))
		     && !q_q[QW-1] && (q_q < $signed({2'b00, w}));
		raddr = (base_q >= delta_q) ? base_q - delta_q : base_q + AW'(Depth) - delta_q;
		status.emit      = !ign && (n >= d);
		status.scan_done = (pi_q == s - SW'(1)) && (qi_q == s - SW'(1));
		status.out_free  = !m_tvalid || m_tready;
	end

	dcmf_ram #(.Width(8), .Depth(Depth)) u_line_store (
		.clk   (clk),
		.we    (cmd.accept && !ign),
		.waddr (wa),
		.wdata (val),
		.re    (cmd.step && rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q    <= '0;
			wa_q      <= '0;
			orow_q    <= '0;
			ocol_q    <= '0;
			rvalid_s1 <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.step && rd_en;
			if (cmd.accept) begin
				item_q <= ign ? '0 : n + ICW'(1);
				wa_q   <= ign ? '0 : ((wa == AW'(Depth - 1)) ? '0 : wa + AW'(1));
				orow_q <= orow;
				ocol_q <= ocol;
				if (status.emit) begin
					if (last_m) begin
						item_q <= '0;
						wa_q   <= '0;
						orow_q <= '0;
						ocol_q <= '0;
					end else if (ocol == w - CW'(1)) begin
						ocol_q <= '0;
						orow_q <= orow + HgtW'(1);
					end else begin
						ocol_q <= ocol + CW'(1);
					end
				end
			end
			if (cmd.load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_q     <= last_m;
			base_q     <= wa;
			p_q        <= $signed({2'b00, orow}) - $signed(PW'(half));
			q_q        <= $signed({2'b00, ocol}) - $signed(QW'(half));
			q0_q       <= $signed({2'b00, ocol}) - $signed(QW'(half));
			pi_q       <= '0;
			qi_q       <= '0;
			delta_q    <= base_delta;
			rowdelta_q <= base_delta;
			min_q      <= White;
		end else begin
			if (cmd.step) begin
				if (qi_q == s - SW'(1)) begin
					qi_q       <= '0;
					pi_q       <= pi_q + SW'(1);
					p_q        <= p_q + PW'(1);
					q_q        <= q0_q;
					rowdelta_q <= rowdelta_q - AW'(w);
					delta_q    <= rowdelta_q - AW'(w);
				end else begin
					qi_q    <= qi_q + SW'(1);
					q_q     <= q_q + QW'(1);
					delta_q <= delta_q - AW'(1);
				end
			end
			if (rvalid_s1 && rdata < min_q) begin
				min_q <= rdata;
			end
		end
		if (cmd.load) begin
			dark_value    <= min_q;
			last_of_frame <= last_q;
		end
	end
endmodule

// ----- sv/dark_channel_min_filter_top.sv -----
// top level of the dark channel window minimum filter
// an item that yields a result has its window walked, then its min goes to the output
// register once it is free; one item every cycle while no result is due, else none until
// that load, as the single read port of the line store visits each window position in turn
// reset: arst_n clears frame counters and control, registers return to 640 x 480, window 15
// the line store has no reset; every entry read was written earlier in the same frame
module dark_channel_min_filter_top #(
	parameter int MaxWidth  = dcmf_pkg::MaxWidthDef,
	parameter int MaxWindow = dcmf_pkg::MaxWindowDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration writes
	input  logic                         cfg_we,
	input  logic [dcmf_pkg::CfgIdxW-1:0] cfg_addr,
	input  logic [dcmf_pkg::CfgW-1:0]    cfg_data,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,   // blue[7:0], green[15:8], red[23:16]
	input  logic                         s_tuser,   // opcode: pixel or flush
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // dark_value[7:0]
	output logic                         m_tlast    // last_of_frame
);
	import dcmf_pkg::*;

	dcmf_cmd_t    cmd;
	dcmf_status_t status;

	// sequencer: idle, walk the window, wait for last read, hand off result
	dcmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// line store, counters and the min over the window
	dcmf_dp #(.MaxWidth(MaxWidth), .MaxWindow(MaxWindow)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.opcode        (s_tuser),
		.blue          (s_tdata[7:0]),
		.green         (s_tdata[15:8]),
		.red           (s_tdata[23:16]),
		.cmd           (cmd),
		.status        (status),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.dark_value    (m_tdata),
		.last_of_frame (m_tlast)
	);
endmodule

// ----- sv/dcmf_checker.sv -----
// port level checks of the dark channel filter, bound to the top level
module dcmf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped under stall");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed under stall");

	// a fresh result never appears right after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result without window scan");

	// while a result is still loading no item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("input taken during scan");
endmodule

bind dark_channel_min_filter_top dcmf_checker u_dcmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- dv/dcmf_checker.sv -----
// checker that predicts dark channel results from the input items and compares them
module dcmf_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [dcmf_pkg::CfgIdxW-1:0] cfg_addr,
	input  logic [dcmf_pkg::CfgW-1:0]    cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);
	import dcmf_pkg::*;

	localparam int Depth = MaxWindowDef * (MaxWidthDef + 1);

	typedef struct packed {
		logic [7:0] dark;
		logic       last;
	} dark_result_t;

	logic [7:0]   pixel_mins [Depth];
	int unsigned  frame_index;
	logic [11:0]  width_reg;
	logic [12:0]  height_reg;
	logic [3:0]   win_reg;
	dark_result_t dark_queue [$];

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// one accepted item; pushes its result, if any
	task automatic predict_dark(input logic flush, input logic [23:0] px);
		int unsigned w, h, s, total, rad, delay, n, m, v;
		int row, col, half, p, q;
		logic [7:0] mn, val;
		w = clip(width_reg, 1, MaxWidthDef);
		h = clip(height_reg, 1, HeightCap);
		s = clip(win_reg, 1, MaxWindowDef);
		total = w * h;
		rad = (s - 1) / 2;
		delay = rad * w + rad;
		if (frame_index >= total + delay) frame_index = 0;
		n = frame_index;
		if (flush && n == 0) return;
		if (flush) val = White;
		else begin
			val = px[7:0];
			if (px[15:8] < val) val = px[15:8];
			if (px[23:16] < val) val = px[23:16];
		end
		pixel_mins[n % Depth] = val;
		frame_index = n + 1;
		if (n < delay) return;
		m = n - delay;
		row = m / w;
		col = m % w;
		half = s >> 1;
		mn = White;
		for (p = row - half; p < row - half + int'(s); p++) begin
			if (p < 0 || p >= int'(h)) continue;
			for (q = col - half; q < col - half + int'(s); q++) begin
				if (q < 0 || q >= int'(w)) continue;
				v = p * w + q;
				if (pixel_mins[v % Depth] < mn) mn = pixel_mins[v % Depth];
			end
		end
		dark_queue.push_back('{dark: mn, last: (m == total - 1)});
		if (m == total - 1) frame_index = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dark_result_t exp_r;
		int errs;
		if (!arst_n) begin
			frame_index <= 0;
			width_reg <= 12'd640;
			height_reg <= 13'd480;
			win_reg <= 4'd15;
			fail_count <= 0;
			pending <= 0;
			dark_queue.delete();
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_addr)
					RegImageWidth:  width_reg <= cfg_data[11:0];
					RegImageHeight: height_reg <= cfg_data[12:0];
					RegWindowSize:  win_reg <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (dark_queue.size() == 0) begin
					$error("result with none expected: dark_value %0d", m_tdata);
					errs++;
				end else begin
					exp_r = dark_queue.pop_front();
					if (m_tdata !== exp_r.dark) begin
						$error("dark_value expected %0d actual %0d", exp_r.dark, m_tdata);
						errs++;
					end
					if (m_tlast !== exp_r.last) begin
						$error("last_of_frame expected %0d actual %0d", exp_r.last, m_tlast);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) predict_dark(s_tuser, s_tdata);
			fail_count <= fail_count + errs;
			pending <= dark_queue.size();
		end
	end
endmodule

// ----- dv/tb_dark_channel_min_filter_top.sv -----
// stimulus and verdict for the dark channel minimum filter
module tb_dark_channel_min_filter_top;
	import dcmf_pkg::*;

	localparam logic OpPixel = 1'b0;
	localparam logic OpFlush = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_addr = '0;
	logic [CfgW-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	int fail_count;
	int pending;

	// sender and receiver idle ratios, zero during the steady stretch
	int send_idle_pct = 31;
	int recv_idle_pct = 31;
	// receiver hold-off in cycles, counted by the receiver process
	int recv_hold = 0;
	int items_sent = 0;
	logic [11:0] cur_w;
	logic [12:0] cur_h;
	logic [3:0] cur_s;

	always #2 clk = ~clk;

	dark_channel_min_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	dcmf_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one item, with a random gap before it; returns at the falling edge after acceptance
	task automatic send_item(input logic op, input logic [23:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait until the block is idle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (240) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [11:0] w, input logic [12:0] h, input logic [3:0] s);
		write_reg(RegImageWidth, CfgW'(w));
		write_reg(RegImageHeight, CfgW'(h));
		write_reg(RegWindowSize, CfgW'(s));
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
		cur_s = s;
	endtask

	// random pixel: mostly full range, sometimes extremes
	function automatic logic [23:0] rand_pixel();
		case ($urandom_range(5))
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	// one well-formed frame at the current geometry, with optional noise
	task automatic send_frame(input bit noisy);
		int unsigned w, h, s, rad, d, k;
		w = (cur_w == 0) ? 1 : (cur_w > MaxWidthDef ? MaxWidthDef : cur_w);
		h = (cur_h == 0) ? 1 : (cur_h > HeightCap ? HeightCap : cur_h);
		s = (cur_s == 0) ? 1 : cur_s;
		rad = (s - 1) / 2;
		d = rad * w + rad;
		// a flush at frame start is ignored
		if (noisy && $urandom_range(3) == 0) send_item(OpFlush, 24'($urandom));
		for (k = 0; k < w * h; k++) begin
			// flush inside the image stores white
			if (noisy && $urandom_range(15) == 0) send_item(OpFlush, 24'($urandom));
			else send_item(OpPixel, rand_pixel());
		end
		// a pixel past the image acts as a flush
		for (k = 0; k < d; k++)
			send_item((noisy && $urandom_range(3) == 0) ? OpPixel : OpFlush, 24'($urandom));
	endtask

	initial begin
		int i, ph;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: 1x1 image with window 1, extremes of every channel
		set_geometry(12'd1, 13'd1, 4'd1);
		send_item(OpFlush, 24'h0);
		send_item(OpPixel, 24'hffffff);
		send_item(OpPixel, 24'h000000);
		send_item(OpPixel, 24'hff00ff);
		send_item(OpPixel, 24'h00ffff);
		send_item(OpPixel, 24'hffff00);
		send_item(OpPixel, 24'haa55aa);
		send_item(OpPixel, 24'h55aa55);
		drain();
		// zero registers act as one
		set_geometry(12'd0, 13'd0, 4'd0);
		send_item(OpPixel, 24'h123456);
		drain();
		// even window on a small image
		set_geometry(12'd3, 13'd2, 4'd2);
		send_frame(1'b1);
		drain();

		// random phases over many geometries, extremes included
		for (ph = 0; items_sent < 1250; ph++) begin
			case (ph % 6)
				0: set_geometry(12'd4095, 13'd1, 4'd15);
				1: set_geometry(12'd2, 13'd8191, 4'd1);
				2: set_geometry(12'(15 + $urandom_range(10)), 13'(14 + $urandom_range(4)), 4'd15);
				default: set_geometry(12'($urandom_range(1, 9)), 13'($urandom_range(1, 6)),
					4'($urandom_range(0, 15)));
			endcase
			if (ph % 6 == 1) begin
				// tall image: only a partial frame, then start over at a fresh size
				for (i = 0; i < 20; i++) send_item(OpPixel, rand_pixel());
				drain();
				set_geometry(12'd1, 13'd1, 4'd1);
				send_item(OpPixel, rand_pixel());
			end else if (ph % 6 == 0) begin
				for (i = 0; i < 40; i++) send_item(OpPixel, rand_pixel());
				drain();
				// register change mid frame drops the old frame
				set_geometry(12'd1, 13'd1, 4'd1);
				send_item(OpPixel, rand_pixel());
			end else begin
				if (ph == 3) begin
					// steady stretch with no idling
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if (ph == 4) begin
					// receiver holds off while the sender keeps offering
					send_idle_pct = 0;
					recv_hold = 1500;
				end
				send_frame(1'b1);
				send_idle_pct = 31;
				recv_idle_pct = 31;
			end
			drain();
		end

		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
sv/dcmf_pkg.sv
sv/dcmf_ram.sv
sv/dcmf_ctrl.sv
sv/dcmf_dp.sv
sv/dark_channel_min_filter_top.sv
sv/dcmf_checker.sv
dv/dcmf_checker.sv
dv/tb_dark_channel_min_filter_top.sv
